// File: rtl/core/pbd_pkg.sv
// Shared widths, codes and types for the point/box distance pipeline.
package pbd_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int TOL_W       = 16;
    localparam int SHIFT_W     = 5;
    localparam int FACE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 3 * COORD_W;
    localparam int OUT_BITS    = ROOT_W + 3 * COORD_W + 1 + FACE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;
    localparam int FRONT_STAGES = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_TOL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REL_SHIFT = 3'd7;

    localparam logic [FACE_W-1:0] FACE_MIN_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_MIN_Y = 3'd1;
    localparam logic [FACE_W-1:0] FACE_MIN_Z = 3'd2;
    localparam logic [FACE_W-1:0] FACE_MAX_X = 3'd3;
    localparam logic [FACE_W-1:0] FACE_MAX_Y = 3'd4;
    localparam logic [FACE_W-1:0] FACE_MAX_Z = 3'd5;
    localparam logic [FACE_W-1:0] FACE_NONE  = 3'd6;

    localparam logic [COORD_W-1:0] BOX_MIN_RESET   = 32'd0;
    localparam logic [COORD_W-1:0] BOX_MAX_RESET   = 32'd65536;
    localparam logic [TOL_W-1:0]   ABS_TOL_RESET   = 16'd0;
    localparam logic [SHIFT_W-1:0] REL_SHIFT_RESET = 5'd17;

    typedef logic [2:0][COORD_W-1:0] t_coord3;

    typedef struct packed {
        t_coord3            lo;
        t_coord3            hi;
        logic [TOL_W-1:0]   abs_tol;
        logic [SHIFT_W-1:0] rel_shift;
    } t_box;

    typedef struct packed {
        t_coord3           near;
        logic              outside;
        logic [FACE_W-1:0] face;
    } t_side;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_side             side;
    } t_cell_data;

endpackage

// File: rtl/core/pbd_front.sv
// Front pipeline: clamp, tolerance test, squares, sum and nearest-face pick.
module pbd_front
    import pbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_box       i_box,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_coord3    i_point,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic [FACE_W-1:0]  idx;
    } t_pick;

    function automatic t_pick pick_min(input t_pick a, input t_pick b);
        t_pick r;
        r = (b.val < a.val) ? b : a;
        return r;
    endfunction

    logic [FRONT_STAGES:0]   w_rdy;
    logic [FRONT_STAGES-1:0] r_v, n_v;

    t_coord3                  r0_p, n0_p;
    t_coord3                  r1_p, n1_p;
    logic [2:0][DIFF_W-1:0]   r1_dlo, n1_dlo, r1_dhi, n1_dhi;
    t_coord3                  r1_mlo, n1_mlo, r1_mhi, n1_mhi;
    t_coord3                  r2_t, n2_t, r2_c, n2_c;
    logic                     r2_out, n2_out;
    t_coord3                  r2_adlo, n2_adlo, r2_adhi, n2_adhi;
    t_coord3                  r2_tollo, n2_tollo, r2_tolhi, n2_tolhi;
    logic [5:0][COORD_W-1:0]  r2_f, n2_f;
    logic [2:0][SQ_W-1:0]     r3_sq, n3_sq;
    logic                     r3_close, n3_close;
    t_coord3                  r3_c, n3_c;
    logic                     r3_out, n3_out;
    t_pick [2:0]              r3_m, n3_m;
    logic [SQ_W:0]            r4_s01, n4_s01;
    logic [SQ_W-1:0]          r4_sq2, n4_sq2;
    t_pick                    r4_ma, n4_ma, r4_m2, n4_m2;
    logic                     r4_close, n4_close;
    t_coord3                  r4_c, n4_c;
    logic                     r4_out, n4_out;
    t_cell_data               r5_data, n5_data;

    always_comb begin
        w_rdy[FRONT_STAGES] = i_ready;
        for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        n_v[0] = w_rdy[0] ? i_valid : r_v[0];
        for (int k = 1; k < FRONT_STAGES; k++) begin
            n_v[k] = w_rdy[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign n0_p = i_point;

    always_comb begin
        n1_p = r0_p;
        for (int i = 0; i < 3; i++) begin
            n1_dlo[i] = {i_box.lo[i][COORD_W-1], i_box.lo[i]} - {r0_p[i][COORD_W-1], r0_p[i]};
            n1_dhi[i] = {r0_p[i][COORD_W-1], r0_p[i]} - {i_box.hi[i][COORD_W-1], i_box.hi[i]};
            n1_mlo[i] = i_box.lo[i][COORD_W-1] ? ({COORD_W{1'b0}} - i_box.lo[i]) : i_box.lo[i];
            n1_mhi[i] = i_box.hi[i][COORD_W-1] ? ({COORD_W{1'b0}} - i_box.hi[i]) : i_box.hi[i];
        end
    end

    always_comb begin
        logic              pos_lo;
        logic              pos_hi;
        logic              lo_gt_hi;
        logic [DIFF_W-1:0] tmp;
        logic [DIFF_W-1:0] neg_lo;
        logic [DIFF_W-1:0] neg_hi;
        n2_out = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pos_lo   = !r1_dlo[i][DIFF_W-1] && (r1_dlo[i] != '0);
            pos_hi   = !r1_dhi[i][DIFF_W-1] && (r1_dhi[i] != '0);
            lo_gt_hi = $signed(i_box.lo[i]) > $signed(i_box.hi[i]);
            tmp = pos_lo ? r1_dlo[i] : '0;
            if ($signed(r1_dhi[i]) > $signed(tmp)) begin
                tmp = r1_dhi[i];
            end
            n2_t[i] = tmp[COORD_W-1:0];
            if (pos_lo) begin
                n2_c[i] = lo_gt_hi ? i_box.hi[i] : i_box.lo[i];
            end else if (pos_hi) begin
                n2_c[i] = i_box.hi[i];
            end else begin
                n2_c[i] = r1_p[i];
            end
            n2_out = n2_out || pos_lo || pos_hi;
            neg_lo = {DIFF_W{1'b0}} - r1_dlo[i];
            neg_hi = {DIFF_W{1'b0}} - r1_dhi[i];
            n2_adlo[i] = r1_dlo[i][DIFF_W-1] ? neg_lo[COORD_W-1:0] : r1_dlo[i][COORD_W-1:0];
            n2_adhi[i] = r1_dhi[i][DIFF_W-1] ? neg_hi[COORD_W-1:0] : r1_dhi[i][COORD_W-1:0];
            n2_tollo[i] = {{(COORD_W-TOL_W){1'b0}}, i_box.abs_tol}
                        + (r1_mlo[i] >> i_box.rel_shift);
            n2_tolhi[i] = {{(COORD_W-TOL_W){1'b0}}, i_box.abs_tol}
                        + (r1_mhi[i] >> i_box.rel_shift);
            n2_f[i]     = neg_lo[COORD_W-1:0];
            n2_f[i+3]   = neg_hi[COORD_W-1:0];
        end
    end

    always_comb begin
        n3_close = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n3_sq[i] = r2_t[i] * r2_t[i];
            n3_close = n3_close || (r2_adlo[i] <= r2_tollo[i]) || (r2_adhi[i] <= r2_tolhi[i]);
        end
        n3_c   = r2_c;
        n3_out = r2_out;
        n3_m[0] = pick_min('{val: r2_f[FACE_MIN_X], idx: FACE_MIN_X},
                           '{val: r2_f[FACE_MIN_Y], idx: FACE_MIN_Y});
        n3_m[1] = pick_min('{val: r2_f[FACE_MIN_Z], idx: FACE_MIN_Z},
                           '{val: r2_f[FACE_MAX_X], idx: FACE_MAX_X});
        n3_m[2] = pick_min('{val: r2_f[FACE_MAX_Y], idx: FACE_MAX_Y},
                           '{val: r2_f[FACE_MAX_Z], idx: FACE_MAX_Z});
    end

    always_comb begin
        n4_s01   = {1'b0, r3_sq[0]} + {1'b0, r3_sq[1]};
        n4_sq2   = r3_sq[2];
        n4_ma    = pick_min(r3_m[0], r3_m[1]);
        n4_m2    = r3_m[2];
        n4_close = r3_close;
        n4_c     = r3_c;
        n4_out   = r3_out;
    end

    always_comb begin
        t_pick best;
        best = pick_min(r4_ma, r4_m2);
        n5_data.rad          = {1'b0, r4_s01} + {2'b00, r4_sq2};
        n5_data.rem          = '0;
        n5_data.root         = '0;
        n5_data.side.near    = r4_c;
        n5_data.side.outside = r4_out;
        n5_data.side.face    = FACE_NONE;
        if (!r4_out && !r4_close) begin
            n5_data.side.face = best.idx;
            case (best.idx)
                FACE_MIN_X: n5_data.side.near[0] = i_box.lo[0];
                FACE_MIN_Y: n5_data.side.near[1] = i_box.lo[1];
                FACE_MIN_Z: n5_data.side.near[2] = i_box.lo[2];
                FACE_MAX_X: n5_data.side.near[0] = i_box.hi[0];
                FACE_MAX_Y: n5_data.side.near[1] = i_box.hi[1];
                FACE_MAX_Z: n5_data.side.near[2] = i_box.hi[2];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_p <= n0_p;
        end
        if (w_rdy[1]) begin
            r1_p   <= n1_p;
            r1_dlo <= n1_dlo;
            r1_dhi <= n1_dhi;
            r1_mlo <= n1_mlo;
            r1_mhi <= n1_mhi;
        end
        if (w_rdy[2]) begin
            r2_t     <= n2_t;
            r2_c     <= n2_c;
            r2_out   <= n2_out;
            r2_adlo  <= n2_adlo;
            r2_adhi  <= n2_adhi;
            r2_tollo <= n2_tollo;
            r2_tolhi <= n2_tolhi;
            r2_f     <= n2_f;
        end
        if (w_rdy[3]) begin
            r3_sq    <= n3_sq;
            r3_close <= n3_close;
            r3_c     <= n3_c;
            r3_out   <= n3_out;
            r3_m     <= n3_m;
        end
        if (w_rdy[4]) begin
            r4_s01   <= n4_s01;
            r4_sq2   <= n4_sq2;
            r4_ma    <= n4_ma;
            r4_m2    <= n4_m2;
            r4_close <= n4_close;
            r4_c     <= n4_c;
            r4_out   <= n4_out;
        end
        if (w_rdy[5]) begin
            r5_data <= n5_data;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_data  = r5_data;

endmodule

// File: rtl/core/pbd_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per word.
module pbd_sqrt_cell
    import pbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell_data i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic       r_valid, n_valid;
    t_cell_data r_data, n_data;

    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             take;
        rem_sh = {i_data.rem[REM_W-3:0], i_data.rad[SUM_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, i_data.root, 2'b01};
        take   = rem_sh >= trial;
        n_data.rad  = {i_data.rad[SUM_W-3:0], 2'b00};
        n_data.rem  = take ? (rem_sh - trial) : rem_sh;
        n_data.root = {i_data.root[ROOT_W-2:0], take};
        n_data.side = i_data.side;
    end

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/point_box_distance_and_projection.sv
// Top level: box registers, front pipeline and the square root cell chain.
//
// Takes one query point per clock unless the output stalls and returns, for
// each, the distance to the configured axis-aligned box (truncated square root,
// zero inside), the closest boundary point, an outside flag and the snapped
// face. Throughput is one word per cycle while the output does not stall; each
// result passes six front stages (clamp, tolerance, squaring, sum, face pick)
// and then a chain of 33 square root cells that each settle one root bit. Every
// stage holds a word of its own, so a stall at the output only halts the stages
// behind it once they have closed their gaps. Write the box registers only
// while no point is in flight.
module point_box_distance_and_projection
    import pbd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // px, py, pz
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // box_distance, near_x, near_y, near_z, is_outside, face_chosen, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_box       r_box, n_box;
    t_coord3    w_point;
    logic       [ROOT_W:0] w_cv;
    logic       [ROOT_W:0] w_crdy;
    t_cell_data w_cd [ROOT_W+1];
    t_cell_data w_last;

    always_comb begin
        n_box = r_box;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_X:     n_box.lo[0]     = i_cfg_data[COORD_W-1:0];
                REG_MIN_Y:     n_box.lo[1]     = i_cfg_data[COORD_W-1:0];
                REG_MIN_Z:     n_box.lo[2]     = i_cfg_data[COORD_W-1:0];
                REG_MAX_X:     n_box.hi[0]     = i_cfg_data[COORD_W-1:0];
                REG_MAX_Y:     n_box.hi[1]     = i_cfg_data[COORD_W-1:0];
                REG_MAX_Z:     n_box.hi[2]     = i_cfg_data[COORD_W-1:0];
                REG_ABS_TOL:   n_box.abs_tol   = i_cfg_data[TOL_W-1:0];
                REG_REL_SHIFT: n_box.rel_shift = i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.lo        <= {3{BOX_MIN_RESET}};
            r_box.hi        <= {3{BOX_MAX_RESET}};
            r_box.abs_tol   <= ABS_TOL_RESET;
            r_box.rel_shift <= REL_SHIFT_RESET;
        end else begin
            r_box <= n_box;
        end
    end

    assign w_point = i_s_axis_tdata;

    pbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (r_box),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_point (w_point),
        .o_valid (w_cv[0]),
        .i_ready (w_crdy[0]),
        .o_data  (w_cd[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        pbd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .o_ready (w_crdy[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .i_ready (w_crdy[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    assign w_crdy[ROOT_W]  = i_m_axis_tready;
    assign w_last          = w_cd[ROOT_W];
    assign o_m_axis_tvalid = w_cv[ROOT_W];
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, w_last.side.face, w_last.side.outside,
                              w_last.side.near, w_last.root};

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output slot is empty");

    a_dist_matches_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_last.side.outside == (w_last.root != '0)))
        else $error("distance disagrees with outside flag");

    a_face_only_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_last.side.face != FACE_NONE) |-> !w_last.side.outside)
        else $error("face snapped for an outside point");
`endif

endmodule

// File: sim/point_box_distance_and_projection_tb.sv
// Self-checking stream testbench: predicts distance, projection and face for every point.
`timescale 1ns / 100ps

module point_box_distance_and_projection_tb;
    import pbd_pkg::*;

    localparam longint COORD_LO = -(64'sd1 <<< 31);
    localparam longint COORD_HI = (64'sd1 <<< 31) - 1;

    // Output word fields from the highest bit down, so a cast unpacks tdata.
    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic               outside;
        logic [COORD_W-1:0] near_z;
        logic [COORD_W-1:0] near_y;
        logic [COORD_W-1:0] near_x;
        logic [ROOT_W-1:0]  distance;
    } t_box_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // px, py, pz
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // box_distance, near_x, near_y, near_z, is_outside, face_chosen, zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Box registers as the block should hold them.
    longint      box_lo[3] = '{0, 0, 0};
    longint      box_hi[3] = '{65536, 65536, 65536};
    int unsigned abs_tol = 0;
    int unsigned rel_shift = 17;

    logic [IN_TDATA_W-1:0] pending_points[$];
    t_box_result           expected_results[$];
    int  n_points = 0;
    int  n_results = 0;
    int  n_mismatch = 0;
    int  n_outside = 0;
    int  n_snapped = 0;
    int  n_settings = 1;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  word_taken = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    point_box_distance_and_projection DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic logic [COORD_W-1:0] to_coord(longint v);
        if (v < COORD_LO) v = COORD_LO;
        if (v > COORD_HI) v = COORD_HI;
        return v[COORD_W-1:0];
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit near_bound(longint c, longint b);
        longint tol;
        tol = longint'(abs_tol) + (abs_of(b) >> rel_shift);
        return abs_of(c - b) <= tol;
    endfunction

    function automatic t_box_result project_point(logic [IN_TDATA_W-1:0] word);
        longint            p[3];
        longint            c[3];
        longint            gap[6];
        longint            t;
        logic [SUM_W-1:0]  tt;
        logic [SUM_W-1:0]  sq_sum;
        logic [67:0]       cand;
        logic [67:0]       root;
        bit                outside;
        bit                close;
        int                best;
        t_box_result       r;
        sq_sum = '0;
        root = '0;
        outside = 1'b0;
        close = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(word[i*COORD_W +: COORD_W]));
            t = box_lo[i] - p[i];
            if (t < 0) t = 0;
            if (p[i] - box_hi[i] > t) t = p[i] - box_hi[i];
            tt = SUM_W'(t);
            sq_sum = sq_sum + tt * tt;
            c[i] = (p[i] < box_lo[i]) ? box_lo[i] : p[i];
            if (c[i] > box_hi[i]) c[i] = box_hi[i];
            if (p[i] < box_lo[i] || p[i] > box_hi[i]) outside = 1'b1;
        end
        for (int b = ROOT_W; b >= 0; b--) begin
            cand = root | (68'd1 << b);
            if (cand * cand <= 68'(sq_sum)) root = cand;
        end
        if (root > ((68'd1 << ROOT_W) - 1)) root = (68'd1 << ROOT_W) - 1;
        r.face = FACE_NONE;
        if (!outside) begin
            for (int i = 0; i < 3; i++)
                if (near_bound(c[i], box_lo[i]) || near_bound(c[i], box_hi[i])) close = 1'b1;
            if (!close) begin
                for (int i = 0; i < 3; i++) begin
                    gap[i] = c[i] - box_lo[i];
                    gap[i+3] = box_hi[i] - c[i];
                end
                best = 0;
                for (int i = 1; i < 6; i++)
                    if (gap[i] < gap[best]) best = i;
                r.face = FACE_W'(best);
                if (best < 3) c[best] = box_lo[best];
                else c[best-3] = box_hi[best-3];
            end
        end
        r.distance = root[ROOT_W-1:0];
        r.near_x = c[0][COORD_W-1:0];
        r.near_y = c[1][COORD_W-1:0];
        r.near_z = c[2][COORD_W-1:0];
        r.outside = outside;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int axis, int mode);
        longint            lo_v;
        longint            hi_v;
        longint            span;
        longint            ext;
        longint            b;
        longint            v;
        longint unsigned   r;
        lo_v = box_lo[axis];
        hi_v = box_hi[axis];
        r = {$urandom, $urandom};
        case (mode)
            0: return $urandom;
            1: begin
                if (hi_v < lo_v) return to_coord(lo_v);
                span = hi_v - lo_v;
                v = lo_v + longint'(r % longint'(span + 1));
            end
            2: begin
                b = $urandom_range(0, 1) ? lo_v : hi_v;
                ext = longint'(abs_tol) + (abs_of(b) >> rel_shift) + 2;
                v = b - ext + longint'(r % longint'(2 * ext + 1));
            end
            default: begin
                span = abs_of(hi_v - lo_v);
                ext = span / 4 + 16;
                lo_v = (hi_v < lo_v) ? hi_v : lo_v;
                v = lo_v - ext + longint'(r % longint'(span + 2 * ext + 1));
            end
        endcase
        return to_coord(v);
    endfunction

    task automatic add_point(longint x, longint y, longint z);
        pending_points.push_back({to_coord(z), to_coord(y), to_coord(x)});
        n_points++;
    endtask

    task automatic add_random_points(int count);
        logic [COORD_W-1:0] q[3];
        int                 pick;
        int                 axis;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            axis = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                if (pick < 45) q[i] = rand_coord(i, 1);
                else if (pick < 60) q[i] = rand_coord(i, (i == axis) ? 2 : 1);
                else if (pick < 85) q[i] = rand_coord(i, $urandom_range(1, 3));
                else q[i] = rand_coord(i, 0);
            end
            pending_points.push_back({q[2], q[1], q[0]});
            n_points++;
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MIN_X, REG_MIN_Y, REG_MIN_Z: box_lo[idx] = longint'($signed(data));
            REG_MAX_X, REG_MAX_Y, REG_MAX_Z: box_hi[idx - REG_MAX_X] = longint'($signed(data));
            REG_ABS_TOL: abs_tol = data[TOL_W-1:0];
            REG_REL_SHIFT: rel_shift = data[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_box(longint lo_v[3], longint hi_v[3], int unsigned tol, int unsigned sh);
        cfg_write(REG_MIN_X, to_coord(lo_v[0]));
        cfg_write(REG_MIN_Y, to_coord(lo_v[1]));
        cfg_write(REG_MIN_Z, to_coord(lo_v[2]));
        cfg_write(REG_MAX_X, to_coord(hi_v[0]));
        cfg_write(REG_MAX_Y, to_coord(hi_v[1]));
        cfg_write(REG_MAX_Z, to_coord(hi_v[2]));
        cfg_write(REG_ABS_TOL, CFG_DATA_W'(tol));
        cfg_write(REG_REL_SHIFT, CFG_DATA_W'(sh));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic load_random_box();
        longint lo_v[3];
        longint hi_v[3];
        longint span;
        for (int k = 0; k < 3; k++) begin
            lo_v[k] = longint'($signed($urandom)) >>> $urandom_range(0, 16);
            case ($urandom_range(0, 2))
                0: span = $urandom_range(0, 16);
                1: span = $urandom_range(0, 1 << 20);
                default: span = longint'($urandom);
            endcase
            hi_v[k] = ($urandom_range(0, 9) == 0) ? lo_v[k] - span - 1 : lo_v[k] + span;
        end
        load_box(lo_v, hi_v, $urandom_range(0, 65535), $urandom_range(0, 31));
    endtask

    task automatic wait_drained();
        while (n_results != n_points) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d of %0d results checked", n_results, n_points);
        $display("*** FAILED ***");
        $finish;
    end

    // Point sender.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_axis_tvalid && !word_taken)) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_axis_tdata <= pending_points.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off to back the pipeline up.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && n_results >= 100) begin
            hold_left <= 400;
            hold_done <= 1'b1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_box_result got;
        t_box_result want;
        word_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = project_point(i_s_axis_tdata);
                if (want.outside) n_outside++;
                if (want.face != FACE_NONE) n_snapped++;
                expected_results.push_back(want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_box_result'(o_m_axis_tdata[OUT_BITS-1:0]);
                if (expected_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("Unexpected result word %h", o_m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.distance !== want.distance || got.near_x !== want.near_x ||
                        got.near_y !== want.near_y || got.near_z !== want.near_z ||
                        got.outside !== want.outside || got.face !== want.face) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"Result %0d: exp dist %0d near %h %h %h out %b face %0d, ",
                                      "got dist %0d near %h %h %h out %b face %0d"},
                                     n_results, want.distance, want.near_x, want.near_y,
                                     want.near_z, want.outside, want.face, got.distance,
                                     got.near_x, got.near_y, got.near_z, got.outside,
                                     got.face);
                    end
                end
                n_results++;
            end
        end
    end

    initial begin
        longint lo_v[3];
        longint hi_v[3];
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 65;
        // reset box (0 to 65536): centre tie, extremes, faces, snaps and near misses
        add_point(32768, 32768, 32768);
        add_point(COORD_LO, COORD_LO, COORD_LO);
        add_point(COORD_HI, COORD_HI, COORD_HI);
        add_point(COORD_LO, COORD_HI, 0);
        add_point(0, 30000, 40000);
        add_point(10000, 32768, 32768);
        add_point(32768, 60000, 32768);
        add_point(32768, 32768, 1);
        add_point(32768, 32768, 65535);
        add_point(65537, 0, 0);
        add_point(-1, 32768, 32768);
        add_point(50000, 15536, 32768);
        add_point(0, 0, 0);
        add_random_points(216);
        wait_drained();

        lo_v = '{-262144, -65536, 0};
        hi_v = '{262144, 131072, 524288};
        load_box(lo_v, hi_v, 256, 10);
        add_random_points(216);
        wait_drained();

        lo_v = '{COORD_LO, COORD_LO, COORD_LO};
        hi_v = '{COORD_HI, COORD_HI, COORD_HI};
        load_box(lo_v, hi_v, 65535, 0);
        add_random_points(216);
        wait_drained();

        send_idle_pct = 65;
        recv_idle_pct = 16;
        load_box(lo_v, hi_v, 0, 31);
        add_random_points(216);
        wait_drained();

        // inverted x, flat z
        lo_v = '{100000, -5, 7};
        hi_v = '{-100000, 5, 7};
        load_box(lo_v, hi_v, 0, 17);
        add_point(0, 0, 7);
        add_point(200000, 0, 7);
        add_point(-200000, 6, 8);
        add_random_points(216);
        wait_drained();

        // flat z only
        lo_v = '{-1000, -1000, 42};
        hi_v = '{1000, 1000, 42};
        load_box(lo_v, hi_v, 0, 31);
        add_point(0, 0, 42);
        add_point(0, 0, 43);
        add_point(999, -999, 42);
        add_random_points(216);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 3; n++) begin
            load_random_box();
            add_random_points(216);
            wait_drained();
        end

        repeat (60) @(negedge i_clk);
        $display("Checked %0d results over %0d box settings: %0d outside, %0d snapped to a face.",
                 n_results, n_settings, n_outside, n_snapped);
        $display("%0d mismatches, %0d results still awaited.", n_mismatch,
                 expected_results.size());
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
